[rtl/core/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/hed_pkg.sv]
// Shared types, character codes and the named reference table of the decoder.
package hed_pkg;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  localparam int unsigned NumNames = 5;

  // Work for one input beat, handed from the decoder to the emitter.
  // gen[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] gen;
    logic [2:0]      gen_n;
    logic            fa_ovf;
    logic            marker;
    logic            last;
  } job_t;

  function automatic logic [2:0] name_len(input logic [2:0] idx);
    case (idx)
      3'd0:    return 3'd6;
      3'd1:    return 3'd6;
      3'd2:    return 3'd4;
      3'd3:    return 3'd4;
      3'd4:    return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] name_value(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h22;
      3'd1:    return 8'h27;
      3'd2:    return 8'h3C;
      3'd3:    return 8'h3E;
      3'd4:    return 8'h26;
      default: return 8'h00;
    endcase
  endfunction

  // Names are left aligned in six characters.
  function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [47:0] text;
    case (idx)
      3'd0:    text = "&quot;";
      3'd1:    text = "&apos;";
      3'd2:    text = {"&lt;", 16'h0000};
      3'd3:    text = {"&gt;", 16'h0000};
      3'd4:    text = {"&amp;", 8'h00};
      default: text = '0;
    endcase
    case (pos)
      3'd0:    return text[47:40];
      3'd1:    return text[39:32];
      3'd2:    return text[31:24];
      3'd3:    return text[23:16];
      3'd4:    return text[15:8];
      3'd5:    return text[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage

[rtl/core/hed_in_if.sv]
// Input byte channel.
interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/core/hed_out_if.sv]
// Decoded byte channel.
interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic       overflow;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  output overflow, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  input overflow, output ready);
endinterface

[rtl/core/hed_ram.sv]
// Generic single write port RAM with registered read.
module hed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/hed_decode.sv]
// Tag stripper and reference parser: turns each input beat into one job.
module hed_decode #(
  parameter int unsigned MAX_PENDING = 16,
  localparam int unsigned CW = $clog2(MAX_PENDING + 1),
  localparam int unsigned AW = $clog2(MAX_PENDING)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  hed_in_if.sink          in_i,
  input  logic            job_free_i,
  output logic            load_o,
  output hed_pkg::job_t   job_o,
  output logic [CW-1:0]   fa_n_o,
  output logic [CW-1:0]   fb_n_o,
  output logic            wr_en_o,
  output logic [AW-1:0]   wr_addr_o,
  output logic [7:0]      wr_data_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhName = 2'd1;
  localparam logic [1:0] PhHash = 2'd2;
  localparam logic [1:0] PhNum  = 2'd3;

  logic          strip_q;
  logic          tag_q, tag_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    phase_q, phase_d;
  logic          hex_q, hex_d;
  logic [31:0]   code_q, code_d;
  logic [hed_pkg::NumNames-1:0] mask_q, mask_d;

  logic          accept;
  logic [7:0]    b;
  logic          pass;
  logic          scan, ext, go_idle;
  logic          hit;
  logic [7:0]    hit_val;
  logic [hed_pkg::NumNames-1:0] part;
  logic          dig_ok;
  logic [3:0]    dig_val;
  logic          hex_en;
  logic [CW-1:0] fa_n, fb_n;
  logic          ovf;
  logic [2:0]    gen_n;
  logic [3:0][7:0] gen;
  logic [31:0]   code_next;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = job_free_i;
  assign b         = in_i.in_byte;
  assign hex_en    = (phase_q == PhNum) && hex_q;

  // digit value for the current radix
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'h0;
    if (b >= hed_pkg::Ch0 && b <= hed_pkg::Ch9) begin
      dig_ok  = 1'b1;
      dig_val = 4'(b - hed_pkg::Ch0);
    end else if (hex_en && b >= hed_pkg::ChLowA && b <= hed_pkg::ChLowF) begin
      dig_ok  = 1'b1;
      dig_val = 4'(b - hed_pkg::ChLowA + 8'd10);
    end else if (hex_en && b >= hed_pkg::ChUpA && b <= hed_pkg::ChUpF) begin
      dig_ok  = 1'b1;
      dig_val = 4'(b - hed_pkg::ChUpA + 8'd10);
    end
  end

  assign code_next = hex_q ? ({code_q[27:0], 4'h0} + 32'(dig_val))
                           : ({code_q[28:0], 3'b000} + {code_q[30:0], 1'b0} + 32'(dig_val));

  // mask_q holds the names whose prefix still matches the held bytes
  always_comb begin
    hit     = 1'b0;
    hit_val = 8'h00;
    part    = '0;
    for (int i = 0; i < hed_pkg::NumNames; i++) begin
      if (mask_q[i] && (cnt_q < CW'(hed_pkg::name_len(3'(i)))) &&
          (hed_pkg::name_char(3'(i), cnt_q[2:0]) == b)) begin
        if ((cnt_q + CW'(1)) == CW'(hed_pkg::name_len(3'(i)))) begin
          if (!hit) begin
            hit     = 1'b1;
            hit_val = hed_pkg::name_value(3'(i));
          end
        end else begin
          part[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    tag_d     = tag_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    hex_d     = hex_q;
    code_d    = code_q;
    mask_d    = mask_q;
    pass      = 1'b1;
    scan      = 1'b0;
    ext       = 1'b0;
    go_idle   = 1'b0;
    fa_n      = '0;
    fb_n      = '0;
    ovf       = 1'b0;
    gen_n     = 3'd0;
    gen       = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = hed_pkg::ChAmp;

    if (strip_q) begin
      if (b == hed_pkg::ChLt) begin
        tag_d = 1'b1;
        pass  = 1'b0;
      end else if (b == hed_pkg::ChGt) begin
        tag_d = 1'b0;
        pass  = 1'b0;
      end else if (tag_q) begin
        pass = 1'b0;
      end
    end

    if (pass) begin
      case (phase_q)
        PhIdle: begin
          scan = 1'b1;
        end
        PhName: begin
          if (cnt_q == CW'(1) && b == hed_pkg::ChHash) begin
            phase_d = PhHash;
            ext     = 1'b1;
          end else if (hit) begin
            go_idle = 1'b1;
            gen_n   = 3'd1;
            gen[0]  = hit_val;
          end else if (|part) begin
            mask_d = part;
            ext    = 1'b1;
          end else begin
            fa_n    = cnt_q;
            go_idle = 1'b1;
            scan    = 1'b1;
          end
        end
        default: begin
          if (b == hed_pkg::ChSemi) begin
            go_idle = 1'b1;
            if (code_q < 32'h80) begin
              gen_n  = 3'd1;
              gen[0] = code_q[7:0];
            end else if (code_q < 32'h800) begin
              gen_n  = 3'd2;
              gen[0] = 8'hC0 | {3'b000, code_q[10:6]};
              gen[1] = 8'h80 | {2'b00, code_q[5:0]};
            end else if (code_q < 32'h10000) begin
              gen_n  = 3'd3;
              gen[0] = 8'hE0 | {4'h0, code_q[15:12]};
              gen[1] = 8'h80 | {2'b00, code_q[11:6]};
              gen[2] = 8'h80 | {2'b00, code_q[5:0]};
            end else begin
              gen_n  = 3'd4;
              gen[0] = 8'hF0 | code_q[25:18];
              gen[1] = 8'h80 | {2'b00, code_q[17:12]};
              gen[2] = 8'h80 | {2'b00, code_q[11:6]};
              gen[3] = 8'h80 | {2'b00, code_q[5:0]};
            end
          end else if (phase_q == PhHash &&
                       (b == hed_pkg::ChLowX || b == hed_pkg::ChUpX)) begin
            hex_d   = 1'b1;
            phase_d = PhNum;
            ext     = 1'b1;
          end else if (dig_ok) begin
            code_d  = code_next;
            phase_d = PhNum;
            ext     = 1'b1;
          end else begin
            fa_n    = cnt_q;
            go_idle = 1'b1;
            scan    = 1'b1;
          end
        end
      endcase
    end

    // append; a full buffer flushes with overflow and the byte is rescanned
    if (ext) begin
      if (cnt_q >= CW'(MAX_PENDING)) begin
        fa_n    = cnt_q;
        ovf     = 1'b1;
        go_idle = 1'b1;
        scan    = 1'b1;
      end else begin
        wr_en_o   = 1'b1;
        wr_addr_o = cnt_q[AW-1:0];
        wr_data_o = b;
        cnt_d     = cnt_q + CW'(1);
      end
    end

    if (go_idle) begin
      cnt_d   = '0;
      phase_d = PhIdle;
      hex_d   = 1'b0;
      code_d  = '0;
    end

    // entry 0 always holds '&' once a candidate is open
    if (scan) begin
      if (b == hed_pkg::ChAmp) begin
        wr_en_o   = 1'b1;
        wr_addr_o = '0;
        wr_data_o = hed_pkg::ChAmp;
        cnt_d     = CW'(1);
        phase_d   = PhName;
        mask_d    = '1;
      end else begin
        gen_n  = 3'd1;
        gen[0] = b;
      end
    end

    if (in_i.in_last) begin
      fb_n    = cnt_d;
      cnt_d   = '0;
      phase_d = PhIdle;
      hex_d   = 1'b0;
      code_d  = '0;
      tag_d   = 1'b0;
    end

    wr_en_o = wr_en_o && accept;
  end

  assign load_o       = accept;
  assign fa_n_o       = fa_n;
  assign fb_n_o       = fb_n;
  assign job_o.gen    = gen;
  assign job_o.gen_n  = gen_n;
  assign job_o.fa_ovf = ovf;
  assign job_o.marker = in_i.in_last && (fa_n == '0) && (gen_n == 3'd0) && (fb_n == '0);
  assign job_o.last   = in_i.in_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b0;
      tag_q   <= 1'b0;
      cnt_q   <= '0;
      phase_q <= PhIdle;
      hex_q   <= 1'b0;
      code_q  <= '0;
      mask_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        strip_q <= cfg_wdata_i;
      end
      if (accept) begin
        tag_q   <= tag_d;
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        hex_q   <= hex_d;
        code_q  <= code_d;
        mask_q  <= mask_d;
      end
    end
  end

endmodule

[rtl/core/hed_emit.sv]
// Beat sequencer: walks a job one result per cycle, unless the output stalls, into the output register.
module hed_emit #(
  parameter int unsigned MAX_PENDING = 16,
  localparam int unsigned CW = $clog2(MAX_PENDING + 1),
  localparam int unsigned AW = $clog2(MAX_PENDING),
  localparam int unsigned RW = $clog2(2 * MAX_PENDING + 6)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  hed_pkg::job_t   job_i,
  input  logic [CW-1:0]   fa_n_i,
  input  logic [CW-1:0]   fb_n_i,
  output logic            job_free_o,
  output logic            rd_en_o,
  output logic [AW-1:0]   rd_addr_o,
  input  logic [7:0]      rd_data_i,
  hed_out_if.source       out_o
);

  logic [RW-1:0]   rem_q, rem_d;
  logic [CW-1:0]   fa_rem_q, fa_rem_d;
  logic [CW-1:0]   fb_rem_q, fb_rem_d;
  logic [2:0]      gen_rem_q, gen_rem_d;
  logic [3:0][7:0] gen_q, gen_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;

  logic            o_valid_q, o_valid_d;
  logic            o_ram_q, o_ram_d;
  logic [7:0]      o_byte_q, o_byte_d;
  logic            o_bv_q, o_bv_d;
  logic            o_last_q, o_last_d;
  logic            o_ovf_q, o_ovf_d;

  logic adv, busy, sel_fa, sel_gen, sel_fb;

  assign adv        = !o_valid_q || out_o.ready;
  assign busy       = (rem_q != '0);
  assign job_free_o = !busy || ((rem_q == RW'(1)) && adv);

  // order within a job: failed flush, generated bytes, end flush, marker
  assign sel_fa  = (fa_rem_q != '0);
  assign sel_gen = !sel_fa && (gen_rem_q != 3'd0);
  assign sel_fb  = !sel_fa && !sel_gen && (fb_rem_q != '0);

  assign rd_en_o   = adv && busy && (sel_fa || sel_fb);
  assign rd_addr_o = idx_q;

  always_comb begin
    rem_d     = rem_q;
    fa_rem_d  = fa_rem_q;
    fb_rem_d  = fb_rem_q;
    gen_rem_d = gen_rem_q;
    gen_d     = gen_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    last_d    = last_q;

    if (adv && busy) begin
      rem_d = rem_q - RW'(1);
      if (sel_fa) begin
        fa_rem_d = fa_rem_q - CW'(1);
        idx_d    = (fa_rem_q == CW'(1)) ? '0 : idx_q + AW'(1);
      end else if (sel_gen) begin
        gen_rem_d = gen_rem_q - 3'd1;
        gen_d     = {8'h00, gen_q[3:1]};
      end else if (sel_fb) begin
        fb_rem_d = fb_rem_q - CW'(1);
        idx_d    = idx_q + AW'(1);
      end
    end

    if (load_i) begin
      rem_d     = RW'(fa_n_i) + RW'(job_i.gen_n) + RW'(fb_n_i) + RW'(job_i.marker);
      fa_rem_d  = fa_n_i;
      fb_rem_d  = fb_n_i;
      gen_rem_d = job_i.gen_n;
      gen_d     = job_i.gen;
      idx_d     = '0;
      ovf_d     = job_i.fa_ovf;
      last_d    = job_i.last;
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    o_ram_d   = o_ram_q;
    o_byte_d  = o_byte_q;
    o_bv_d    = o_bv_q;
    o_last_d  = o_last_q;
    o_ovf_d   = o_ovf_q;
    if (adv) begin
      o_valid_d = busy;
      o_ram_d   = sel_fa || sel_fb;
      o_byte_d  = sel_gen ? gen_q[0] : 8'h00;
      o_bv_d    = sel_fa || sel_gen || sel_fb;
      o_last_d  = last_q && (rem_q == RW'(1));
      o_ovf_d   = sel_fa && ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      fa_rem_q  <= '0;
      fb_rem_q  <= '0;
      gen_rem_q <= 3'd0;
      o_valid_q <= 1'b0;
    end else begin
      rem_q     <= rem_d;
      fa_rem_q  <= fa_rem_d;
      fb_rem_q  <= fb_rem_d;
      gen_rem_q <= gen_rem_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q    <= gen_d;
    idx_q    <= idx_d;
    ovf_q    <= ovf_d;
    last_q   <= last_d;
    o_ram_q  <= o_ram_d;
    o_byte_q <= o_byte_d;
    o_bv_q   <= o_bv_d;
    o_last_q <= o_last_d;
    o_ovf_q  <= o_ovf_d;
  end

  // RAM read data holds while the output beat is stalled
  assign out_o.valid      = o_valid_q;
  assign out_o.out_byte   = o_ram_q ? rd_data_i : o_byte_q;
  assign out_o.byte_valid = o_bv_q;
  assign out_o.out_last   = o_last_q;
  assign out_o.overflow   = o_ovf_q;

endmodule

[rtl/core/html_entity_decoder.sv]
// Top level of the streaming HTML character reference decoder.
//
// in_i carries one text byte per beat with in_last on the final byte of a
// string; out_o carries decoded bytes, with byte_valid low on a bare end
// marker, out_last on the final result of a string and overflow on bytes
// flushed because a candidate reference outgrew MAX_PENDING bytes.
// cfg_we_i/cfg_wdata_i write strip_markup; write only while the block is idle.
// A beat's first result is registered in the sequencer, then in the output
// register. Throughput: one result per cycle unless the receiver stalls. A
// beat giving n results (n up to 2*MAX_PENDING+5, at most MAX_PENDING+1 in
// practice) holds the sequencer; the next beat is taken in the cycle its last
// result moves to the output register, and a beat giving no result leaves it free.
// The rate is set by the single output register and the RAM's one read port.
// Reset clears parser state, strip_markup and the output; the held-byte RAM is
// not cleared, since only entries written for the open candidate are read.
// When the receiver stalls, the output beat holds and input stops while the
// sequencer still holds results of the current job.
module html_entity_decoder #(
  parameter int unsigned MAX_PENDING = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  hed_in_if.sink   in_i,
  hed_out_if.source out_o
);

  localparam int unsigned CW = $clog2(MAX_PENDING + 1);
  localparam int unsigned AW = $clog2(MAX_PENDING);

  logic            job_free;
  logic            load;
  hed_pkg::job_t   job;
  logic [CW-1:0]   fa_n, fb_n;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;

  hed_decode #(.MAX_PENDING(MAX_PENDING)) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .job_free_i  (job_free),
    .load_o      (load),
    .job_o       (job),
    .fa_n_o      (fa_n),
    .fb_n_o      (fb_n),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  hed_ram #(.WIDTH(8), .DEPTH(MAX_PENDING)) u_pending (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  hed_emit #(.MAX_PENDING(MAX_PENDING)) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .job_i      (job),
    .fa_n_i     (fa_n),
    .fb_n_i     (fb_n),
    .job_free_o (job_free),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_o      (out_o)
  );

endmodule

[rtl/core/html_entity_decoder_chk.sv]
// Port level checks for the decoder, bound to the top level.
`include "assert_macros.svh"

module html_entity_decoder_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       out_last_i,
  input logic       overflow_i
);

  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(byte_valid_i) && $stable(out_last_i) && $stable(overflow_i), "stalled output beat changed")
  `ASSERT_CLKD(a_marker_shape, clk_i, rst_ni, out_valid_i && !byte_valid_i |-> out_last_i && (out_byte_i == 8'h00) && !overflow_i, "malformed end marker")
  `ASSERT_CLKD(a_ovf_not_last, clk_i, rst_ni, out_valid_i && overflow_i |-> byte_valid_i && !out_last_i, "overflow beat ends a string")
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "output valid during reset")

endmodule

bind html_entity_decoder html_entity_decoder_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .byte_valid_i (out_o.byte_valid),
  .out_last_i   (out_o.out_last),
  .overflow_i   (out_o.overflow)
);
